// ----- design/mfrh_pkg.sv -----
`default_nettype none

package mfrh_pkg;

  // lane geometry
  localparam int unsigned MAX_LANES  = 16;
  localparam int unsigned LANE_W     = $clog2(MAX_LANES);
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BYTES      = WORD_W / BYTE_W;
  localparam int unsigned BYTE_IDX_W = $clog2(BYTES);
  localparam int unsigned COUNT_W    = 4;

  // a count of a full word selects the word mix
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BYTES);

  // hash constants
  localparam logic [WORD_W-1:0] FNV_BASIS   = 64'hCBF29CE484222325;
  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;

  // fnv prime 0x100000001b3 split as 2^40 + 0x1b3
  localparam int unsigned PRIME_SHIFT = 40;
  localparam int unsigned PRIME_LO_W  = 9;
  localparam logic [PRIME_LO_W-1:0] PRIME_LO = 9'h1B3;

  // word mix rotate and xor-shift amounts
  localparam int unsigned ROTL = 31;
  localparam int unsigned XSHR = 33;

  // per-lane seed: basis xor lane times golden step, mod 2^64
  function automatic logic [MAX_LANES-1:0][WORD_W-1:0] seed_table();
    logic [MAX_LANES-1:0][WORD_W-1:0] t;
    for (int i = 0; i < MAX_LANES; i++) begin
      t[i] = FNV_BASIS ^ (WORD_W'(i) * GOLDEN_STEP);
    end
    return t;
  endfunction

  localparam logic [MAX_LANES-1:0][WORD_W-1:0] LANE_SEED = seed_table();

  // mix unit control
  typedef struct packed {
    logic                  full;
    logic [BYTE_IDX_W-1:0] byte_sel;
  } mix_ctl_t;

endpackage

`default_nettype wire

// ----- design/mfrh_lane_mix.sv -----
`default_nettype none

module mfrh_lane_mix import mfrh_pkg::*; (
  input  logic [WORD_W-1:0] hash_i,
  input  logic [WORD_W-1:0] data_i,
  input  mix_ctl_t          ctl_i,
  output logic [WORD_W-1:0] hash_o
);

  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] rot;
  logic [BYTE_W-1:0] sel_byte;

  // pick the byte for the fnv-1a step
  assign sel_byte = data_i[{ctl_i.byte_sel, 3'b000} +: BYTE_W];

  always_comb begin
    // xor in a whole word or one byte
    if (ctl_i.full) begin
      mixed = hash_i ^ data_i;
    end else begin
      mixed = hash_i ^ {{(WORD_W-BYTE_W){1'b0}}, sel_byte};
    end

    // multiply by the prime as shift plus a narrow product
    prod = (mixed << PRIME_SHIFT)
         + (mixed * {{(WORD_W-PRIME_LO_W){1'b0}}, PRIME_LO});

    // rotate left, then fold the high half down
    rot = {prod[WORD_W-1-ROTL:0], prod[WORD_W-1:WORD_W-ROTL]};

    if (ctl_i.full) begin
      hash_o = rot ^ (rot >> XSHR);
    end else begin
      hash_o = prod;
    end
  end

endmodule

`default_nettype wire

// ----- design/multilane_fnv_rotate_hash.sv -----
`default_nettype none

// Multi-lane FNV rotate hash. Sixteen 64-bit lanes all absorb the same byte
// stream; lane_count (1..16, 0 acts as 1, larger values as 16) picks how many
// lanes are sent out as the digest on a beat with tlast set. A small microcode
// table steps one shared mix unit (xor, multiply by the FNV prime, and for a
// full word rotate and xor-shift) over the lanes, one lane per cycle for a full
// word and one byte of one lane per cycle for a partial word. An input beat
// therefore passes through fetch, the lane steps of the sweep and a test step;
// a beat with no valid byte passes through the mix step without writing a lane.
// A beat with tlast then sends one digest beat per configured lane, each held
// until taken. Reseeding on first_item clears the valid bits: the lanes read
// back their seed until rewritten. The configuration channel is always ready;
// write it only while the block is idle.
module multilane_fnv_rotate_hash import mfrh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // lane count register
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [71:0]          s_axis_tdata,  // data_word[63:0], valid_bytes[67:64], zero pad
  input  logic [0:0]           s_axis_tuser,  // first_item[0]
  input  logic                 s_axis_tlast,  // last_item
  // digest stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [WORD_W-1:0]    m_axis_tdata,  // digest_word[63:0]
  output logic [LANE_W-1:0]    m_axis_tuser,  // lane_index[3:0]
  output logic                 m_axis_tlast   // last_lane
);

  typedef enum logic [1:0] {
    ST_FETCH,
    ST_MIX,
    ST_TEST,
    ST_EMIT
  } step_e;

  typedef enum logic [1:0] {
    C_IN_BEAT,
    C_MIX_DONE,
    C_LAST,
    C_EMIT_DONE
  } cond_e;

  typedef struct packed {
    logic  take_in;
    logic  mix;
    logic  emit;
    cond_e cond;
    step_e on_true;
    step_e on_false;
  } uword_t;

  // microcode: one control word per step
  function automatic uword_t ucode(step_e s);
    uword_t w;
    case (s)
      ST_FETCH: w = '{take_in: 1'b1, mix: 1'b0, emit: 1'b0, cond: C_IN_BEAT,
                      on_true: ST_MIX,   on_false: ST_FETCH};
      ST_MIX:   w = '{take_in: 1'b0, mix: 1'b1, emit: 1'b0, cond: C_MIX_DONE,
                      on_true: ST_TEST,  on_false: ST_MIX};
      ST_TEST:  w = '{take_in: 1'b0, mix: 1'b0, emit: 1'b0, cond: C_LAST,
                      on_true: ST_EMIT,  on_false: ST_FETCH};
      ST_EMIT:  w = '{take_in: 1'b0, mix: 1'b0, emit: 1'b1, cond: C_EMIT_DONE,
                      on_true: ST_FETCH, on_false: ST_EMIT};
      default:  w = '{take_in: 1'b0, mix: 1'b0, emit: 1'b0, cond: C_IN_BEAT,
                      on_true: ST_FETCH, on_false: ST_FETCH};
    endcase
    return w;
  endfunction

  step_e                 step_q, step_d;
  logic [LANE_W-1:0]     lane_q, lane_d;
  logic [BYTE_IDX_W-1:0] byte_q, byte_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic                  last_q, last_d;
  logic [WORD_W-1:0]     data_q, data_d;
  logic [LANE_W-1:0]     last_idx_q, last_idx_d;
  logic [MAX_LANES-1:0]  valid_q, valid_d;
  logic [WORD_W-1:0]     lane_hash_q [MAX_LANES];

  uword_t             uw;
  logic               in_beat;
  logic               out_beat;
  logic               cond_true;
  logic [COUNT_W-1:0] in_count;
  logic [COUNT_W-1:0] sat_count;
  logic               full_word;
  logic               no_bytes;
  logic               byte_end;
  logic               lane_end;
  logic               mix_done;
  logic               emit_done;
  logic               lane_wr;
  logic [WORD_W-1:0]  lane_cur;
  logic [WORD_W-1:0]  lane_new;
  mix_ctl_t           mix_ctl;

  assign uw = ucode(step_q);

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = uw.take_in;
  assign in_beat       = s_axis_tvalid & uw.take_in;
  assign m_axis_tvalid = uw.emit;
  assign out_beat      = uw.emit & m_axis_tready;

  // byte count, saturated to a full word
  assign in_count  = s_axis_tdata[WORD_W +: COUNT_W];
  assign sat_count = (in_count > FULL_COUNT) ? FULL_COUNT : in_count;

  // sweep bookkeeping
  assign full_word = (count_q == FULL_COUNT);
  assign no_bytes  = (count_q == '0);
  assign byte_end  = full_word | ({1'b0, byte_q} == (count_q - COUNT_W'(1)));
  assign lane_end  = (lane_q == LANE_W'(MAX_LANES - 1));
  assign mix_done  = no_bytes | (lane_end & byte_end);
  assign emit_done = out_beat & (lane_q == last_idx_q);
  assign lane_wr   = uw.mix & ~no_bytes;

  // jump condition
  always_comb begin
    case (uw.cond)
      C_IN_BEAT:   cond_true = in_beat;
      C_MIX_DONE:  cond_true = mix_done;
      C_LAST:      cond_true = last_q;
      C_EMIT_DONE: cond_true = emit_done;
      default:     cond_true = 1'b0;
    endcase
  end

  assign step_d = cond_true ? uw.on_true : uw.on_false;

  // lane read, unwritten lanes give their seed
  assign lane_cur = valid_q[lane_q] ? lane_hash_q[lane_q] : LANE_SEED[lane_q];

  assign mix_ctl.full     = full_word;
  assign mix_ctl.byte_sel = byte_q;

  mfrh_lane_mix u_mix (
    .hash_i (lane_cur),
    .data_i (data_q),
    .ctl_i  (mix_ctl),
    .hash_o (lane_new)
  );

  // digest output
  assign m_axis_tdata = lane_cur;
  assign m_axis_tuser = lane_q;
  assign m_axis_tlast = (lane_q == last_idx_q);

  // next-state for counters, capture and valid bits
  always_comb begin
    lane_d     = lane_q;
    byte_d     = byte_q;
    count_d    = count_q;
    last_d     = last_q;
    data_d     = data_q;
    valid_d    = valid_q;
    last_idx_d = last_idx_q;

    if (in_beat) begin
      data_d  = s_axis_tdata[WORD_W-1:0];
      count_d = sat_count;
      last_d  = s_axis_tlast;
      lane_d  = '0;
      byte_d  = '0;
      if (s_axis_tuser[0]) begin
        valid_d = '0;
      end
    end

    if (lane_wr) begin
      valid_d[lane_q] = 1'b1;
      if (byte_end) begin
        lane_d = lane_q + LANE_W'(1);
        byte_d = '0;
      end else begin
        byte_d = byte_q + BYTE_IDX_W'(1);
      end
    end

    if (out_beat) begin
      lane_d = emit_done ? '0 : lane_q + LANE_W'(1);
    end

    // lane count stored as last lane index, clamped
    if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        last_idx_d = '0;
      end else if (cfg_data_i > CFG_W'(MAX_LANES)) begin
        last_idx_d = LANE_W'(MAX_LANES - 1);
      end else begin
        last_idx_d = LANE_W'(cfg_data_i - CFG_W'(1));
      end
    end
  end

  // sequencer and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= ST_FETCH;
      lane_q     <= '0;
      byte_q     <= '0;
      count_q    <= '0;
      last_q     <= 1'b0;
      valid_q    <= '0;
      last_idx_q <= '0;
    end else begin
      step_q     <= step_d;
      lane_q     <= lane_d;
      byte_q     <= byte_d;
      count_q    <= count_d;
      last_q     <= last_d;
      valid_q    <= valid_d;
      last_idx_q <= last_idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (lane_wr) begin
      lane_hash_q[lane_q] <= lane_new;
    end
  end

  // digest beats never overlap input beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("digest beat offered while input is taken");

  // final digest beat ends the emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("digest continues past last lane");

  // lane index stays within the configured count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= last_idx_q))
    else $error("lane index beyond lane count");

  // byte pointer stays below the byte count in a partial sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.mix && !no_bytes && !full_word) |-> ({1'b0, byte_q} < count_q))
    else $error("byte pointer past valid bytes");

endmodule

`default_nettype wire
